/* hdl/stes_pkg.sv */
// Shared types and constants of the spanning tree edge selector.
// Used by stes_cell and spanning_tree_edge_selector; depends on nothing.
package stes_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int LABEL_W      = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = LABEL_W + 1;
   localparam int VERTEX_W     = 6;
   localparam int WEIGHT_W     = 16;
   localparam int COST_W       = 22;
   localparam int EDGES_W      = 6;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(64);
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_MIN   = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_MAX   = COUNT_W'(MAX_VERTICES);
   localparam logic [COST_W-1:0]  COST_MAX           = {COST_W{1'b1}};

   typedef logic [LABEL_W-1:0] label_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] edge_from;
      logic [VERTEX_W-1:0] edge_to;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                last_edge;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [COST_W-1:0]   tree_cost;
      logic [EDGES_W-1:0]  tree_edges;
      logic                tree_done;
   } rsp_type;

   // Lookup token that walks the cell row.
   typedef struct packed {
      logic                valid;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      label_type           from_label;
      label_type           to_label;
   } token_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic                merge;
      logic                clear;
      label_type           old_label;
      label_type           new_label;
      logic [COUNT_W-1:0]  limit;
   } merge_type;

endpackage

/* hdl/spanning_tree_edge_selector.sv */
// Top level of the spanning tree edge selector: controller, cost and count, cell row.
// Depends on stes_pkg and stes_cell.
//
// Takes edges in nondecreasing weight order and keeps each edge with both ends below the
// vertex count that joins two different components before the tree is full (Kruskal).
// For each edge a lookup token walks the row of vertex cells, one cell per cycle, to
// collect the component labels of both end vertices, then the merge step merges the two
// components in every cell at once and loads the result register. The next edge is
// taken in the cycle after that, so no new edge is taken before the previous one is done.
// A new edge is taken while a finished result still waits on the rsp channel; only its
// merge cycle waits for the rsp register to free up. The last edge of a graph resets all
// labels, the cost and the count in the same cycle as its result is formed. csr_data sets
// the vertex count; the user must write it only between transactions (not enforced).
module spanning_tree_edge_selector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  stes_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output stes_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stes_pkg::COUNT_W-1:0]    csr_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [stes_pkg::COUNT_W-1:0]     vertex_count_ff;
   stes_pkg::req_type                edge_ff;
   stes_pkg::label_type              from_label_ff, to_label_ff;
   logic [stes_pkg::EDGES_W-1:0]     kept_ff, kept_in;
   logic [stes_pkg::COST_W-1:0]      cost_ff, cost_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   stes_pkg::rsp_type                rsp_ff, rsp_in;

   stes_pkg::token_type              chain [stes_pkg::MAX_VERTICES+1];
   stes_pkg::merge_type              command;

   logic [stes_pkg::COUNT_W-1:0]     active_n;
   logic                             in_range, eligible, finish;
   logic [stes_pkg::COST_W:0]        cost_sum;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (vertex_count_ff < stes_pkg::VERTEX_COUNT_MIN) begin
         active_n = stes_pkg::VERTEX_COUNT_MIN;
      end else if (vertex_count_ff > stes_pkg::VERTEX_COUNT_MAX) begin
         active_n = stes_pkg::VERTEX_COUNT_MAX;
      end else begin
         active_n = vertex_count_ff;
      end
   end

   assign in_range = ({1'b0, kept_ff} < (active_n - 1'b1))
                     && ({1'b0, edge_ff.edge_from} < active_n)
                     && ({1'b0, edge_ff.edge_to} < active_n);
   assign eligible = in_range && (from_label_ff != to_label_ff);
   assign finish   = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);
   assign cost_sum = {1'b0, cost_ff} + (stes_pkg::COST_W + 1)'(edge_ff.edge_weight);

   always_comb begin
      chain[0].valid       = req_valid && req_ready;
      chain[0].from_vertex = req_data.edge_from;
      chain[0].to_vertex   = req_data.edge_to;
      chain[0].from_label  = '0;
      chain[0].to_label    = '0;
   end

   always_comb begin
      command.merge     = finish && eligible;
      command.clear     = finish && edge_ff.last_edge;
      command.old_label = to_label_ff;
      command.new_label = from_label_ff;
      command.limit     = active_n;
   end

   genvar i;
   generate
      for (i = 0; i < stes_pkg::MAX_VERTICES; i++) begin : g_cell
         stes_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (stes_pkg::label_type'(i)),
            .token_in   (chain[i]),
            .command    (command),
            .token_out  (chain[i+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      kept_in      = kept_ff;
      cost_in      = cost_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (chain[stes_pkg::MAX_VERTICES].valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (finish) begin
               if (eligible) begin
                  kept_in = kept_ff + 1'b1;
                  cost_in = cost_sum[stes_pkg::COST_W] ? stes_pkg::COST_MAX
                                                      : cost_sum[stes_pkg::COST_W-1:0];
               end
               rsp_in.accepted   = eligible;
               rsp_in.tree_cost  = cost_in;
               rsp_in.tree_edges = kept_in;
               rsp_in.tree_done  = ({1'b0, kept_in} >= (active_n - 1'b1));
               rsp_valid_in      = 1'b1;
               if (edge_ff.last_edge) begin
                  kept_in = '0;
                  cost_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vertex_count_ff <= stes_pkg::VERTEX_COUNT_RESET;
         kept_ff         <= '0;
         cost_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            vertex_count_ff <= csr_data;
         end
      end
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         edge_ff <= req_data;
      end
      if (chain[stes_pkg::MAX_VERTICES].valid) begin
         from_label_ff <= chain[stes_pkg::MAX_VERTICES].from_label;
         to_label_ff   <= chain[stes_pkg::MAX_VERTICES].to_label;
      end
   end

endmodule

/* hdl/stes_cell.sv */
// One vertex cell: holds the component label of its vertex and passes the lookup token on.
// Depends on stes_pkg.
module stes_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stes_pkg::label_type   cell_index,
   input  stes_pkg::token_type   token_in,
   input  stes_pkg::merge_type   command,
   output stes_pkg::token_type   token_out
);

   stes_pkg::label_type label_ff, label_in;
   stes_pkg::token_type token_ff, token_in_next;

   always_comb begin
      label_in = label_ff;
      if (command.clear) begin
         label_in = cell_index;
      end else if (command.merge && ({1'b0, cell_index} < command.limit)
                   && (label_ff == command.old_label)) begin
         label_in = command.new_label;
      end
   end

   always_comb begin
      token_in_next = token_in;
      if (stes_pkg::label_type'(token_in.from_vertex) == cell_index) begin
         token_in_next.from_label = label_ff;
      end
      if (stes_pkg::label_type'(token_in.to_vertex) == cell_index) begin
         token_in_next.to_label = label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff       <= cell_index;
         token_ff.valid <= 1'b0;
      end else begin
         label_ff       <= label_in;
         token_ff.valid <= token_in_next.valid;
      end
      token_ff.from_vertex <= token_in_next.from_vertex;
      token_ff.to_vertex   <= token_in_next.to_vertex;
      token_ff.from_label  <= token_in_next.from_label;
      token_ff.to_label    <= token_in_next.to_label;
   end

   assign token_out = token_ff;

endmodule
